[rtl/mib_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mib_pkg: shared types for the monochrome image blitter
// Command codes, register indexes, controller states and the draw request
// handed from the source cursor to the memory controller.
// ----------------------------------------------------------------------------
package mib_pkg;

  // Command carried in tuser of the input stream
  typedef enum logic [1:0] {
    CMD_DRAW = 2'd0,
    CMD_FILL = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_e;

  // Memory controller states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_DRAW_ADDR,
    ST_DRAW_RMW0,
    ST_DRAW_RMW1,
    ST_READ_WAIT
  } state_e;

  localparam int unsigned RegW = 10;

  // One draw request: target row, first target byte column and the
  // pixel masks (1 = clear) for that byte and the one to its right
  typedef struct packed {
    logic [9:0] dst_y;
    logic [7:0] bx0;
    logic [7:0] m0;
    logic [7:0] m1;
  } draw_t;

endpackage
`default_nettype wire

[rtl/mib_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mib_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/mib_cursor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mib_cursor: image registers and source position
// Holds the placement registers and the row / byte position of the next
// source byte, and turns a source byte into clipped clear masks.
// ----------------------------------------------------------------------------
module mib_cursor import mib_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [RegW-1:0] cfg_data_i,
  input  wire logic            advance_i,
  input  wire logic [7:0]      image_byte_i,
  output draw_t                draw_o
);

  logic [9:0] left_q, top_q, width_q, height_q;
  logic [9:0] row_q, row_d;
  logic [6:0] col_q, col_d;

  logic [7:0]  row_bytes, next_col;
  logic [9:0]  row_inc;
  logic [10:0] x0, dst_y;
  logic        row_ok;
  logic [7:0]  pix;
  logic [15:0] spread;
  logic [9:0]  colb;
  logic [11:0] dxb;

  // position step: next byte, wrap at row end and image end
  always_comb begin
    row_bytes = 8'((11'(width_q) + 11'd7) >> 3);
    next_col  = {1'b0, col_q} + 8'd1;
    row_inc   = row_q + 10'd1;
    row_d     = row_q;
    col_d     = next_col[6:0];
    if (next_col >= row_bytes) begin
      col_d = '0;
      row_d = (row_inc >= height_q) ? 10'd0 : row_inc;
    end
  end

  // registers and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
      // any register write restarts the image
      row_q <= '0;
      col_q <= '0;
    end else if (advance_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // clipped masks; pixel bit 7-b is image column col*8+b
  always_comb begin
    x0     = 11'(left_q) + {1'b0, col_q, 3'b000};
    dst_y  = 11'(top_q) + 11'(row_q);
    row_ok = (row_q < height_q) && (dst_y < 11'(SCREEN_HEIGHT));
    pix    = '0;
    for (int b = 0; b < 8; b++) begin
      colb = {col_q, 3'(b)};
      dxb  = {1'b0, x0} + 12'(b);
      pix[7-b] = image_byte_i[7-b] && row_ok && (colb < width_q)
                 && (dxb < 12'(SCREEN_WIDTH));
    end
    // split across the two target bytes by the sub-byte offset
    spread       = {pix, 8'h00} >> x0[2:0];
    draw_o.dst_y = dst_y[9:0];
    draw_o.bx0   = x0[10:3];
    draw_o.m0    = spread[15:8];
    draw_o.m1    = spread[7:0];
  end

endmodule
`default_nettype wire

[rtl/monochrome_image_blitter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// monochrome_image_blitter: 1 bpp framebuffer with clipped image drawing
// Owns a packed framebuffer in one RAM. Draw bytes clear pixels by
// read-modify-write, fill sweeps the whole store, read returns one byte.
//
//   channel   dir   handshake              payload
//   s_axis    in    tvalid/tready          tuser: command, tdata: see port
//   m_axis    out   tvalid/tready          tdata: read_data
//   cfg       in    cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// Draw: an address step, then two read-modify-write slots on the RAM's
// single write port. Read: a RAM read, then ST_READ_WAIT, which waits
// while an earlier result is stalled on m_axis. Fill: one RAM write per
// cycle over the whole store. After reset a clearing pass writes 0xFF to
// every byte (48000 bytes at the defaults), with s_axis_tready low.
// A result waits in an output register; a stalled m_axis only holds off
// the next request once a read result is ready behind it.
// ----------------------------------------------------------------------------
module monochrome_image_blitter import mib_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] image_byte, [15:8] fill_value, [31:16] read_address
  input  wire logic [31:0]     s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // [7:0] read_data
  output logic      [7:0]      m_axis_tdata,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [RegW-1:0] cfg_data_i
);

  localparam int RowBytes = (SCREEN_WIDTH + 7) / 8;
  localparam int StoreBytes = RowBytes * SCREEN_HEIGHT;
  localparam int AW = $clog2(StoreBytes);

  state_e        state_q, state_d;
  logic [AW-1:0] fill_ptr_q, fill_ptr_d;
  logic [7:0]    fill_val_q, fill_val_d;
  draw_t         draw_q, draw_d, draw_c;
  logic [AW-1:0] idx_q, idx_d, idx1;
  logic          oob_q, oob_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q, out_data_d;

  logic          s_acc;
  cmd_e          cmd;
  logic [7:0]    image_byte, fill_value;
  logic [15:0]   read_address;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign cmd          = cmd_e'(s_axis_tuser);
  assign image_byte   = s_axis_tdata[7:0];
  assign fill_value   = s_axis_tdata[15:8];
  assign read_address = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign idx1          = idx_q + AW'(1);

  // source cursor and mask generation
  mib_cursor #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (s_acc && (cmd == CMD_DRAW)),
    .image_byte_i(image_byte),
    .draw_o      (draw_c)
  );

  // framebuffer
  mib_ram #(
    .WIDTH(8),
    .DEPTH(StoreBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_ptr_q  <= '0;
      fill_val_q  <= 8'hFF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_ptr_q  <= fill_ptr_d;
      fill_val_q  <= fill_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    draw_q     <= draw_d;
    idx_q      <= idx_d;
    oob_q      <= oob_d;
    out_data_q <= out_data_d;
  end

  // next state and RAM control
  always_comb begin
    state_d     = state_q;
    fill_ptr_d  = fill_ptr_q;
    fill_val_d  = fill_val_q;
    draw_d      = draw_q;
    idx_d       = idx_q;
    oob_d       = oob_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;

    case (state_q)
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_ptr_q;
        ram_wdata = fill_val_q;
        if (fill_ptr_q == AW'(StoreBytes - 1)) begin
          fill_ptr_d = '0;
          state_d    = ST_IDLE;
        end else begin
          fill_ptr_d = fill_ptr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          case (cmd)
            CMD_DRAW: begin
              draw_d  = draw_c;
              state_d = ST_DRAW_ADDR;
            end
            CMD_FILL: begin
              fill_val_d = fill_value;
              fill_ptr_d = '0;
              state_d    = ST_FILL;
            end
            CMD_READ: begin
              oob_d     = (32'(read_address) >= 32'(StoreBytes));
              ram_re    = !oob_d;
              ram_raddr = AW'(read_address);
              state_d   = ST_READ_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_DRAW_ADDR: begin
        idx_d     = AW'(32'(draw_q.dst_y) * RowBytes + 32'(draw_q.bx0));
        ram_re    = (draw_q.m0 != 8'h00);
        ram_raddr = idx_d;
        state_d   = ST_DRAW_RMW0;
      end
      ST_DRAW_RMW0: begin
        // write back the first byte, fetch its right neighbor
        ram_we    = (draw_q.m0 != 8'h00);
        ram_waddr = idx_q;
        ram_wdata = ram_rdata & ~draw_q.m0;
        ram_re    = (draw_q.m1 != 8'h00);
        ram_raddr = idx1;
        state_d   = ST_DRAW_RMW1;
      end
      ST_DRAW_RMW1: begin
        ram_we    = (draw_q.m1 != 8'h00);
        ram_waddr = idx1;
        ram_wdata = ram_rdata & ~draw_q.m1;
        state_d   = ST_IDLE;
      end
      ST_READ_WAIT: begin
        // RAM data holds until the output register frees up
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = oob_q ? 8'h00 : ram_rdata;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // the two draw slots never write and read the same byte at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write collide on one address");

  // a read with a free output passes through ST_READ_WAIT, then shows its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && cmd == CMD_READ && !out_valid_q) |-> ##2 out_valid_q)
    else $error("read result not delivered in time");

  // the sweep pointer rests at zero outside a fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FILL) |-> (fill_ptr_q == '0))
    else $error("fill pointer left nonzero");

  // the input stays closed for the whole draw sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && cmd == CMD_DRAW) |=> (!s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready))
    else $error("request accepted during a draw");

endmodule
`default_nettype wire
